>>> design/assert_macros.svh
// Assertion macros used by the ordered timer queue design file.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/otq_pkg.sv
// Package for the ordered timer queue: field codes, chain command type and widths.
// Used by otq_cell and ordered_timer_queue; depends on nothing.
package otq_pkg;

    localparam int unsigned IdW      = 4;
    localparam int unsigned KindW    = 2;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned LeadW    = 48;
    localparam int unsigned DataW    = 56;

    localparam logic [KindW-1:0] KIND_ARM    = 2'd0;
    localparam logic [KindW-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KindW-1:0] KIND_RUN    = 2'd2;
    localparam logic [KindW-1:0] KIND_QUERY  = 2'd3;

    localparam logic [StatusW-1:0] STAT_DONE    = 2'd0;
    localparam logic [StatusW-1:0] STAT_EXPIRED = 2'd1;
    localparam logic [StatusW-1:0] STAT_LEAD    = 2'd2;
    localparam logic [StatusW-1:0] STAT_EMPTY   = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    typedef struct packed {
        logic [1:0]     op;
        logic [IdW-1:0] id;
    } otq_cmd_t;

endpackage

>>> design/otq_cell.sv
// One cell of the sorted timer chain: holds one pending slot and its deadline.
// Depends on otq_pkg for the chain command type and operation codes.
module otq_cell
    import otq_pkg::*;
#(
    parameter int unsigned TICK_BITS = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  otq_cmd_t             cmd,
    input  logic [TICK_BITS-1:0] new_tick,
    input  logic                 shift_in,
    input  logic                 ins_in,
    input  logic                 left_valid,
    input  logic [IdW-1:0]       left_id,
    input  logic [TICK_BITS-1:0] left_tick,
    input  logic                 right_valid,
    input  logic [IdW-1:0]       right_id,
    input  logic [TICK_BITS-1:0] right_tick,
    output logic                 cell_valid,
    output logic [IdW-1:0]       cell_id,
    output logic [TICK_BITS-1:0] cell_tick,
    output logic                 shift_out,
    output logic                 ins_out
);

    logic                 valid_reg, valid_next;
    logic [IdW-1:0]       id_reg, id_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;

    // A removal shifts every cell from the matching one onward.
    assign shift_out = shift_in | (valid_reg & (id_reg == cmd.id));
    // The new entry goes before the first cell with a strictly later deadline.
    assign ins_out   = ~valid_reg | (new_tick < tick_reg);

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        tick_next  = tick_reg;
        unique case (cmd.op)
            OP_REMOVE: begin
                if (shift_out) begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    tick_next  = right_tick;
                end
            end
            OP_INSERT: begin
                if (ins_in) begin
                    valid_next = left_valid;
                    id_next    = left_id;
                    tick_next  = left_tick;
                end else if (ins_out) begin
                    valid_next = 1'b1;
                    id_next    = cmd.id;
                    tick_next  = new_tick;
                end
            end
            OP_POP: begin
                valid_next = right_valid;
                id_next    = right_id;
                tick_next  = right_tick;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        tick_reg <= tick_next;
    end

    assign cell_valid = valid_reg;
    assign cell_id    = id_reg;
    assign cell_tick  = tick_reg;

endmodule

>>> design/ordered_timer_queue.sv
// Ordered timer queue: arm passes ST_REMOVE then ST_INSERT, cancel ST_REMOVE, query ST_QUERY.
// Run pops one due slot per result while the output is free (at least one result is given).
// Every chain operation acts on all cells at once, and items are taken one at a time.
// Synchronous active-low reset empties the chain and clears the output valid flag.
// Depends on otq_pkg, otq_cell and assert_macros.svh.
`include "assert_macros.svh"
module ordered_timer_queue
    import otq_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 16,
    parameter int unsigned TICK_BITS = 48
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DataW-1:0]   s_tdata,   // slot_id, tick_value, zero padding
    input  logic [KindW-1:0]   s_tuser,   // kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DataW-1:0]   m_tdata,   // expired_id, lead_tick, zero padding
    output logic [StatusW-1:0] m_tuser,   // status
    output logic               m_tlast
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REMOVE = 3'd1;
    localparam logic [2:0] ST_INSERT = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;
    localparam logic [2:0] ST_RUN    = 3'd4;
    localparam logic [2:0] ST_QUERY  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [KindW-1:0]     kind_reg;
    logic [IdW-1:0]       id_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic [TICK_BITS-1:0] in_tick;
    logic [LeadW-1:0]     head_lead;

    logic                 out_valid_reg;
    logic [StatusW-1:0]   out_status_reg;
    logic [IdW-1:0]       out_id_reg;
    logic [LeadW-1:0]     out_lead_reg;
    logic                 out_last_reg;

    logic                 emit;
    logic [StatusW-1:0]   emit_status;
    logic [IdW-1:0]       emit_id;
    logic [LeadW-1:0]     emit_lead;
    logic                 emit_last;
    logic                 out_free;
    logic                 in_range;
    logic                 head_due;
    logic                 next_due;
    otq_cmd_t             cmd;

    logic [NUM_SLOTS-1:0] cell_valid;
    logic [IdW-1:0]       cell_id   [NUM_SLOTS];
    logic [TICK_BITS-1:0] cell_tick [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] shift_chain;
    logic [NUM_SLOTS-1:0] ins_chain;

    generate
        if (TICK_BITS == LeadW) begin : g_equal
            assign in_tick   = s_tdata[IdW +: TICK_BITS];
            assign head_lead = cell_tick[0];
        end else if (TICK_BITS < LeadW) begin : g_narrow
            assign in_tick   = s_tdata[IdW +: TICK_BITS];
            assign head_lead = {{(LeadW - TICK_BITS){1'b0}}, cell_tick[0]};
        end else begin : g_wide
            assign in_tick   = {{(TICK_BITS - LeadW){1'b0}}, s_tdata[IdW +: LeadW]};
            assign head_lead = cell_tick[0][LeadW-1:0];
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
            logic                 l_valid, r_valid, s_in, i_in;
            logic [IdW-1:0]       l_id, r_id;
            logic [TICK_BITS-1:0] l_tick, r_tick;
            if (gi == 0) begin : g_head
                assign l_valid = 1'b0;
                assign l_id    = '0;
                assign l_tick  = '0;
                assign s_in    = 1'b0;
                assign i_in    = 1'b0;
            end else begin : g_mid
                assign l_valid = cell_valid[gi-1];
                assign l_id    = cell_id[gi-1];
                assign l_tick  = cell_tick[gi-1];
                assign s_in    = shift_chain[gi-1];
                assign i_in    = ins_chain[gi-1];
            end
            if (gi == NUM_SLOTS - 1) begin : g_tail
                assign r_valid = 1'b0;
                assign r_id    = '0;
                assign r_tick  = '0;
            end else begin : g_inner
                assign r_valid = cell_valid[gi+1];
                assign r_id    = cell_id[gi+1];
                assign r_tick  = cell_tick[gi+1];
            end
            otq_cell #(
                .TICK_BITS(TICK_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .new_tick   (tick_reg),
                .shift_in   (s_in),
                .ins_in     (i_in),
                .left_valid (l_valid),
                .left_id    (l_id),
                .left_tick  (l_tick),
                .right_valid(r_valid),
                .right_id   (r_id),
                .right_tick (r_tick),
                .cell_valid (cell_valid[gi]),
                .cell_id    (cell_id[gi]),
                .cell_tick  (cell_tick[gi]),
                .shift_out  (shift_chain[gi]),
                .ins_out    (ins_chain[gi])
            );
        end
    endgenerate

    assign out_free = ~out_valid_reg | m_tready;
    assign in_range = {{(32 - IdW){1'b0}}, id_reg} < 32'(NUM_SLOTS);
    assign head_due = cell_valid[0] & (cell_tick[0] <= tick_reg);
    assign next_due = cell_valid[1] & (cell_tick[1] <= tick_reg);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd.op      = OP_HOLD;
        cmd.id      = id_reg;
        emit        = 1'b0;
        emit_status = STAT_DONE;
        emit_id     = '0;
        emit_lead   = '0;
        emit_last   = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser) inside
                        KIND_ARM, KIND_CANCEL: state_next = ST_REMOVE;
                        KIND_RUN:              state_next = ST_RUN;
                        default:               state_next = ST_QUERY;
                    endcase
                end
            end
            ST_REMOVE: begin
                cmd.op = OP_REMOVE;
                if (kind_reg == KIND_ARM) begin
                    state_next = ST_INSERT;
                end else if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_INSERT: begin
                if (in_range) begin
                    cmd.op = OP_INSERT;
                end
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (head_due) begin
                        cmd.op      = OP_POP;
                        emit_status = STAT_EXPIRED;
                        emit_id     = cell_id[0];
                        emit_last   = ~next_due;
                        if (!next_due) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_QUERY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (cell_valid[0]) begin
                        emit_status = STAT_LEAD;
                        emit_lead   = head_lead;
                    end else begin
                        emit_status = STAT_EMPTY;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            id_reg   <= s_tdata[IdW-1:0];
            tick_reg <= in_tick;
        end
        if (emit) begin
            out_status_reg <= emit_status;
            out_id_reg     <= emit_id;
            out_lead_reg   <= emit_lead;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(DataW - IdW - LeadW){1'b0}}, out_lead_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_SAME(a_chain_packed, aclk, aresetn, 1'b1,
        ((cell_valid & (cell_valid + 1'b1)) == '0))
    `ASSERT_SAME(a_head_sorted, aclk, aresetn, cell_valid[1],
        (cell_tick[0] <= cell_tick[1]))
    `ASSERT_SAME(a_pop_due, aclk, aresetn, (cmd.op == OP_POP), head_due)
    `ASSERT_NEXT(a_pop_shrinks, aclk, aresetn, (cmd.op == OP_POP),
        ($countones(cell_valid) == $countones($past(cell_valid)) - 1))

endmodule
